// ----- sv/blm_pkg.sv -----
package blm_pkg;

	// fraction bits of the fixed point format
	localparam int FRAC_BITS = 32;
	// golden section fraction 0.3819660 in 32 fraction bits
	localparam logic [31:0] GOLD_Q = 32'd1640531478;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MID      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REL_TOL  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 3'd4;

	// input commands and result kinds
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_VALUE = 1'b1;
	localparam logic KIND_EVAL = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// search phase
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_FIRST = 2'd1;
	localparam logic [1:0] PH_STEP  = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	// sequencer steps, also the datapath command
	localparam int ST_W = 5;
	localparam logic [ST_W-1:0] ST_WAIT   = 5'd0;
	localparam logic [ST_W-1:0] ST_START  = 5'd1;
	localparam logic [ST_W-1:0] ST_OSTART = 5'd2;
	localparam logic [ST_W-1:0] ST_FIRST  = 5'd3;
	localparam logic [ST_W-1:0] ST_TAKE   = 5'd4;
	localparam logic [ST_W-1:0] ST_A0     = 5'd5;
	localparam logic [ST_W-1:0] ST_A1     = 5'd6;
	localparam logic [ST_W-1:0] ST_A2     = 5'd7;
	localparam logic [ST_W-1:0] ST_A3     = 5'd8;
	localparam logic [ST_W-1:0] ST_A4     = 5'd9;
	localparam logic [ST_W-1:0] ST_A5     = 5'd10;
	localparam logic [ST_W-1:0] ST_P0     = 5'd11;
	localparam logic [ST_W-1:0] ST_P1     = 5'd12;
	localparam logic [ST_W-1:0] ST_P2     = 5'd13;
	localparam logic [ST_W-1:0] ST_P3     = 5'd14;
	localparam logic [ST_W-1:0] ST_P4     = 5'd15;
	localparam logic [ST_W-1:0] ST_P5     = 5'd16;
	localparam logic [ST_W-1:0] ST_P6     = 5'd17;
	localparam logic [ST_W-1:0] ST_P7     = 5'd18;
	localparam logic [ST_W-1:0] ST_P8     = 5'd19;
	localparam logic [ST_W-1:0] ST_P9     = 5'd20;
	localparam logic [ST_W-1:0] ST_P10    = 5'd21;
	localparam logic [ST_W-1:0] ST_P11    = 5'd22;
	localparam logic [ST_W-1:0] ST_P12    = 5'd23;
	localparam logic [ST_W-1:0] ST_DIV    = 5'd24;
	localparam logic [ST_W-1:0] ST_D1     = 5'd25;
	localparam logic [ST_W-1:0] ST_D2     = 5'd26;
	localparam logic [ST_W-1:0] ST_G0     = 5'd27;
	localparam logic [ST_W-1:0] ST_G1     = 5'd28;
	localparam logic [ST_W-1:0] ST_F0     = 5'd29;
	localparam logic [ST_W-1:0] ST_OSTEP  = 5'd30;
	localparam logic [ST_W-1:0] ST_OFIN   = 5'd31;

	typedef struct packed {
		logic [ST_W-1:0] st;
		logic            in_load;
		logic            mul_go;
		logic            div_go;
		logic            out_load;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic at_limit;
		logic tol_met;
		logic use_para;
		logic reject;
	} status_t;

endpackage

// ----- sv/blm_if.sv -----
interface blm_in_if #(parameter int W = 64);
	logic                valid;
	logic                ready;
	logic                command;
	logic signed [W-1:0] func_value;
	modport source(output valid, command, func_value, input ready);
	modport sink(input valid, command, func_value, output ready);
endinterface

interface blm_out_if #(parameter int W = 64);
	logic                valid;
	logic                ready;
	logic                kind;
	logic signed [W-1:0] point;
	logic signed [W-1:0] best_value;
	modport source(output valid, kind, point, best_value, input ready);
	modport sink(input valid, kind, point, best_value, output ready);
endinterface

// ----- sv/blm_mul.sv -----
module blm_mul #(
	parameter int W = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [W-1:0]        mag_a,
	input  logic [W-1:0]        mag_b,
	input  logic                neg,
	output logic                done,
	output logic signed [W-1:0] result
);
	localparam int L  = W / 2;
	localparam int HW = W - L;
	localparam int MW = 2 * W - blm_pkg::FRAC_BITS;
	localparam logic [W-1:0] WMAXU = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SIGNU = {1'b1, {(W-1){1'b0}}};

	logic [W-1:0]    am_q, bm_q;
	logic            neg_q, busy_q, done_q;
	logic [1:0]      cnt_q;
	logic [2*W-1:0]  acc_q, acc_nx;
	logic [HW-1:0]   ap, bp;
	logic [2*HW-1:0] pp;
	logic [MW-1:0]   m;

	// one half-by-half partial product per cycle
	always_comb begin
		ap = cnt_q[1] ? HW'(am_q[W-1:L]) : HW'(am_q[L-1:0]);
		bp = cnt_q[0] ? HW'(bm_q[W-1:L]) : HW'(bm_q[L-1:0]);
		pp = ap * bp;
		acc_nx = acc_q + (((2*W)'(pp) << (cnt_q[0] ? L : 0)) << (cnt_q[1] ? L : 0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operands and accumulator
	always_ff @(posedge clk) begin
		if (go) begin
			am_q  <= mag_a;
			bm_q  <= mag_b;
			neg_q <= neg;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_nx;
		end
	end

	// drop fraction bits and saturate
	always_comb begin
		m = acc_q[2*W-1:blm_pkg::FRAC_BITS];
		if (neg_q)
			result = (m >= MW'(SIGNU)) ? $signed(SIGNU) : $signed(~m[W-1:0] + 1'b1);
		else
			result = (m > MW'(WMAXU)) ? $signed(WMAXU) : $signed(m[W-1:0]);
	end

	assign done = done_q;
endmodule

// ----- sv/blm_div.sv -----
module blm_div #(
	parameter int W = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic signed [W-1:0] num,
	input  logic signed [W-1:0] den,
	output logic                done,
	output logic signed [W-1:0] result
);
	localparam int NW = W + blm_pkg::FRAC_BITS;
	localparam int CW = $clog2(NW + 1);
	localparam logic [W-1:0] WMAXU = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SIGNU = {1'b1, {(W-1){1'b0}}};

	logic [NW-1:0] nq_q;
	logic [W:0]    rem_q, rem2, rem_nx;
	logic [W-1:0]  d_q, nmag, dmag;
	logic          neg_q, zero_q, busy_q, done_q, qbit;
	logic [CW-1:0] cnt_q;

	assign nmag = num[W-1] ? (~num + 1'b1) : num;
	assign dmag = den[W-1] ? (~den + 1'b1) : den;

	// one restoring step per cycle
	always_comb begin
		rem2 = {rem_q[W-1:0], nq_q[NW-1]};
		qbit = (rem2 >= {1'b0, d_q});
		rem_nx = qbit ? (rem2 - {1'b0, d_q}) : rem2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			nq_q   <= {nmag, {blm_pkg::FRAC_BITS{1'b0}}};
			rem_q  <= '0;
			d_q    <= dmag;
			neg_q  <= num[W-1] ^ den[W-1];
			zero_q <= (dmag == '0);
		end else if (busy_q) begin
			nq_q  <= {nq_q[NW-2:0], qbit};
			rem_q <= rem_nx;
		end
	end

	// saturate the quotient, zero on a zero divisor
	always_comb begin
		if (zero_q)
			result = '0;
		else if (neg_q)
			result = (nq_q >= NW'(SIGNU)) ? $signed(SIGNU) : $signed(~nq_q[W-1:0] + 1'b1);
		else
			result = (nq_q > NW'(WMAXU)) ? $signed(WMAXU) : $signed(nq_q[W-1:0]);
	end

	assign done = done_q;
endmodule

// ----- sv/blm_datapath.sv -----
module blm_datapath #(
	parameter int W  = 64,
	parameter int IW = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  blm_pkg::cmd_t                 cmd,
	output blm_pkg::status_t              sts,
	input  logic signed [W-1:0]           func_value,
	input  logic                          cfg_we,
	input  logic [blm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [W-1:0]                  cfg_data,
	output logic                          kind,
	output logic signed [W-1:0]           point,
	output logic signed [W-1:0]           best_value
);
	localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] ZERO = '0;
	localparam logic signed [W-1:0] ONE  = W'(1);

	function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a, b);
		logic signed [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		return (s[W] != s[W-1]) ? (s[W] ? WMIN : WMAX) : s[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] a, b);
		logic signed [W:0] s;
		s = {a[W-1], a} - {b[W-1], b};
		return (s[W] != s[W-1]) ? (s[W] ? WMIN : WMAX) : s[W-1:0];
	endfunction

	function automatic logic [W-1:0] mag(input logic signed [W-1:0] a);
		return a[W-1] ? (~a + 1'b1) : a;
	endfunction

	function automatic logic signed [W-1:0] sabs(input logic signed [W-1:0] a);
		return (a == WMIN) ? WMAX : $signed(mag(a));
	endfunction

	function automatic logic signed [W-1:0] half(input logic signed [W-1:0] a);
		logic [W-1:0] h;
		h = mag(a) >> 1;
		return a[W-1] ? $signed(~h + 1'b1) : $signed(h);
	endfunction

	function automatic logic signed [W-1:0] midpt(input logic signed [W-1:0] a, b);
		logic signed [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		return s[W:1];
	endfunction

	// configuration registers
	logic signed [W-1:0] blo_q, bmid_q, bhi_q;
	logic [31:0]         rtol_q;
	logic [15:0]         maxit_q;

	// search state and working values
	logic signed [W-1:0] a_q, b_q, x_q, sx_q, tx_q, bf_q, sf_q, tf_q;
	logic signed [W-1:0] sn_q, sb_q, tr_q, fv_q;
	logic signed [W-1:0] tol1_q, tol2_q, xm_q, e_q, h_q, r_q, q_q, p_q, t_q, u_q, d_q;
	logic signed [W-1:0] prev_q;
	logic [IW-1:0]       it_q;
	logic                rej_q;
	logic                kind_q;
	logic signed [W-1:0] point_q, val_q;

	logic signed [W-1:0] oa, ob, mul_res, div_res, dn, unx;
	logic [W-1:0]        ma, mb;
	logic                mneg, mul_done, div_done;

	// multiplier operands per step
	always_comb begin
		oa = ZERO;
		ob = ZERO;
		case (cmd.st)
			blm_pkg::ST_A1: oa = sabs(x_q);
			blm_pkg::ST_P0: begin
				oa = ssub(x_q, sx_q);
				ob = ssub(bf_q, tf_q);
			end
			blm_pkg::ST_P1: begin
				oa = ssub(x_q, tx_q);
				ob = ssub(bf_q, sf_q);
			end
			blm_pkg::ST_P2: begin
				oa = ssub(x_q, tx_q);
				ob = q_q;
			end
			blm_pkg::ST_P3: begin
				oa = ssub(x_q, sx_q);
				ob = r_q;
			end
			blm_pkg::ST_P7: begin
				oa = q_q;
				ob = prev_q;
			end
			blm_pkg::ST_P9: begin
				oa = q_q;
				ob = ssub(a_q, x_q);
			end
			blm_pkg::ST_P11: begin
				oa = q_q;
				ob = ssub(b_q, x_q);
			end
			blm_pkg::ST_G1: begin
				oa = W'(blm_pkg::GOLD_Q);
				ob = sb_q;
			end
			default: ;
		endcase
		ma = mag(oa);
		mb = (cmd.st == blm_pkg::ST_A1) ? W'(rtol_q) : mag(ob);
		mneg = oa[W-1] ^ ob[W-1];
	end

	blm_mul #(.W(W)) u_mul (
		.clk(clk), .arst_n(arst_n), .go(cmd.mul_go), .mag_a(ma), .mag_b(mb),
		.neg(mneg), .done(mul_done), .result(mul_res)
	);

	blm_div #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .go(cmd.div_go), .num(p_q), .den(q_q),
		.done(div_done), .result(div_res)
	);

	// final step size and trial point
	always_comb begin
		dn = (d_q > ZERO) ? tol1_q : (d_q < ZERO) ? ssub(ZERO, tol1_q) : ZERO;
		unx = (sabs(d_q) >= tol1_q) ? sadd(x_q, d_q) : sadd(x_q, dn);
	end

	// status back to the controller
	always_comb begin
		sts.mul_done = mul_done;
		sts.div_done = div_done;
		sts.at_limit = (32'(it_q) >= 32'(maxit_q));
		sts.tol_met  = (sabs(e_q) <= ssub(tol2_q, h_q));
		sts.use_para = (sabs(sb_q) > tol1_q);
		sts.reject   = rej_q || (p_q >= t_q);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blo_q   <= '0;
			bmid_q  <= '0;
			bhi_q   <= '0;
			rtol_q  <= 32'd1;
			maxit_q <= 16'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				blm_pkg::CFG_LOW:      blo_q   <= cfg_data;
				blm_pkg::CFG_MID:      bmid_q  <= cfg_data;
				blm_pkg::CFG_HIGH:     bhi_q   <= cfg_data;
				blm_pkg::CFG_REL_TOL:  rtol_q  <= cfg_data[31:0];
				blm_pkg::CFG_MAX_ITER: maxit_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// search state updates, one step per command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q  <= '0;
			b_q  <= '0;
			x_q  <= '0;
			sx_q <= '0;
			tx_q <= '0;
			bf_q <= '0;
			sf_q <= '0;
			tf_q <= '0;
			sn_q <= '0;
			sb_q <= '0;
			tr_q <= '0;
			it_q <= '0;
		end else begin
			case (cmd.st)
				blm_pkg::ST_START: begin
					a_q  <= (blo_q < bhi_q) ? blo_q : bhi_q;
					b_q  <= (blo_q > bhi_q) ? blo_q : bhi_q;
					x_q  <= bmid_q;
					sx_q <= bmid_q;
					tx_q <= bmid_q;
					tr_q <= bmid_q;
					bf_q <= '0;
					sf_q <= '0;
					tf_q <= '0;
					sn_q <= '0;
					sb_q <= '0;
					it_q <= '0;
				end
				blm_pkg::ST_FIRST: begin
					bf_q <= fv_q;
					sf_q <= fv_q;
					tf_q <= fv_q;
				end
				blm_pkg::ST_TAKE: begin
					if (fv_q <= bf_q) begin
						if (tr_q >= x_q) a_q <= x_q;
						else b_q <= x_q;
						tx_q <= sx_q;
						sx_q <= x_q;
						x_q  <= tr_q;
						tf_q <= sf_q;
						sf_q <= bf_q;
						bf_q <= fv_q;
					end else begin
						if (tr_q < x_q) a_q <= tr_q;
						else b_q <= tr_q;
						if (fv_q <= sf_q || sx_q == x_q) begin
							tx_q <= sx_q;
							sx_q <= tr_q;
							tf_q <= sf_q;
							sf_q <= fv_q;
						end else if (fv_q <= tf_q || tx_q == x_q || tx_q == sx_q) begin
							tx_q <= tr_q;
							tf_q <= fv_q;
						end
					end
				end
				blm_pkg::ST_P6: sb_q <= sn_q;
				blm_pkg::ST_G0: sb_q <= (x_q >= xm_q) ? ssub(a_q, x_q) : ssub(b_q, x_q);
				blm_pkg::ST_F0: begin
					sn_q <= d_q;
					tr_q <= unx;
					if (it_q != {IW{1'b1}}) it_q <= it_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// working values
	always_ff @(posedge clk) begin
		if (cmd.in_load) fv_q <= func_value;
		if (mul_done) begin
			case (cmd.st)
				blm_pkg::ST_P0: r_q <= mul_res;
				blm_pkg::ST_P1: q_q <= mul_res;
				blm_pkg::ST_P2: p_q <= mul_res;
				blm_pkg::ST_G1: d_q <= mul_res;
				default:        t_q <= mul_res;
			endcase
		end
		if (div_done) d_q <= div_res;
		case (cmd.st)
			blm_pkg::ST_A2: begin
				tol1_q <= sadd(t_q, ONE);
				xm_q   <= midpt(a_q, b_q);
			end
			blm_pkg::ST_A3: begin
				tol2_q <= sadd(tol1_q, tol1_q);
				e_q    <= ssub(x_q, xm_q);
				h_q    <= half(ssub(b_q, a_q));
			end
			blm_pkg::ST_P4: begin
				p_q    <= ssub(p_q, t_q);
				prev_q <= sb_q;
				t_q    <= ssub(q_q, r_q);
			end
			blm_pkg::ST_P5: q_q <= sadd(t_q, t_q);
			blm_pkg::ST_P6: begin
				if (q_q > ZERO) p_q <= ssub(ZERO, p_q);
				q_q <= sabs(q_q);
			end
			blm_pkg::ST_P8:  rej_q <= (sabs(p_q) >= sabs(half(t_q)));
			blm_pkg::ST_P10: rej_q <= rej_q || (p_q <= t_q);
			blm_pkg::ST_D1:  u_q <= sadd(x_q, d_q);
			blm_pkg::ST_D2: begin
				if (ssub(u_q, a_q) < tol2_q || ssub(b_q, u_q) < tol2_q)
					d_q <= (xm_q > x_q) ? tol1_q : (xm_q < x_q) ? ssub(ZERO, tol1_q) : ZERO;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.st)
				blm_pkg::ST_OSTART: begin
					kind_q  <= blm_pkg::KIND_EVAL;
					point_q <= x_q;
					val_q   <= '0;
				end
				blm_pkg::ST_OSTEP: begin
					kind_q  <= blm_pkg::KIND_EVAL;
					point_q <= tr_q;
					val_q   <= bf_q;
				end
				default: begin
					kind_q  <= blm_pkg::KIND_DONE;
					point_q <= x_q;
					val_q   <= bf_q;
				end
			endcase
		end
	end

	assign kind       = kind_q;
	assign point      = point_q;
	assign best_value = val_q;
endmodule

// ----- sv/blm_ctrl.sv -----
module blm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_command,
	output logic             in_ready,
	input  logic             out_ready,
	output logic             out_valid,
	output blm_pkg::cmd_t    cmd,
	input  blm_pkg::status_t sts
);
	logic [blm_pkg::ST_W-1:0] st_q, st_nx;
	logic [1:0]               phase_q;
	logic                     busy_q, accept, out_free, is_mul;

	assign in_ready = (st_q == blm_pkg::ST_WAIT);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	always_comb begin
		case (st_q)
			blm_pkg::ST_A1, blm_pkg::ST_P0, blm_pkg::ST_P1, blm_pkg::ST_P2, blm_pkg::ST_P3,
			blm_pkg::ST_P7, blm_pkg::ST_P9, blm_pkg::ST_P11, blm_pkg::ST_G1: is_mul = 1'b1;
			default: is_mul = 1'b0;
		endcase
	end

	// commands to the datapath
	always_comb begin
		cmd.st       = st_q;
		cmd.in_load  = accept;
		cmd.mul_go   = is_mul && !busy_q;
		cmd.div_go   = (st_q == blm_pkg::ST_DIV) && !busy_q;
		cmd.out_load = out_free && (st_q == blm_pkg::ST_OSTART ||
			st_q == blm_pkg::ST_OSTEP || st_q == blm_pkg::ST_OFIN);
	end

	// next step
	always_comb begin
		st_nx = st_q;
		case (st_q)
			blm_pkg::ST_WAIT: begin
				if (accept) begin
					if (in_command == blm_pkg::CMD_START) st_nx = blm_pkg::ST_START;
					else if (phase_q == blm_pkg::PH_FIRST) st_nx = blm_pkg::ST_FIRST;
					else if (phase_q == blm_pkg::PH_STEP) st_nx = blm_pkg::ST_TAKE;
				end
			end
			blm_pkg::ST_START: st_nx = blm_pkg::ST_OSTART;
			blm_pkg::ST_FIRST, blm_pkg::ST_TAKE: st_nx = blm_pkg::ST_A0;
			blm_pkg::ST_A0: st_nx = sts.at_limit ? blm_pkg::ST_OFIN : blm_pkg::ST_A1;
			blm_pkg::ST_A1: if (sts.mul_done) st_nx = blm_pkg::ST_A2;
			blm_pkg::ST_A2: st_nx = blm_pkg::ST_A3;
			blm_pkg::ST_A3: st_nx = blm_pkg::ST_A4;
			blm_pkg::ST_A4: st_nx = sts.tol_met ? blm_pkg::ST_OFIN : blm_pkg::ST_A5;
			blm_pkg::ST_A5: st_nx = sts.use_para ? blm_pkg::ST_P0 : blm_pkg::ST_G0;
			blm_pkg::ST_P0: if (sts.mul_done) st_nx = blm_pkg::ST_P1;
			blm_pkg::ST_P1: if (sts.mul_done) st_nx = blm_pkg::ST_P2;
			blm_pkg::ST_P2: if (sts.mul_done) st_nx = blm_pkg::ST_P3;
			blm_pkg::ST_P3: if (sts.mul_done) st_nx = blm_pkg::ST_P4;
			blm_pkg::ST_P4: st_nx = blm_pkg::ST_P5;
			blm_pkg::ST_P5: st_nx = blm_pkg::ST_P6;
			blm_pkg::ST_P6: st_nx = blm_pkg::ST_P7;
			blm_pkg::ST_P7: if (sts.mul_done) st_nx = blm_pkg::ST_P8;
			blm_pkg::ST_P8: st_nx = blm_pkg::ST_P9;
			blm_pkg::ST_P9: if (sts.mul_done) st_nx = blm_pkg::ST_P10;
			blm_pkg::ST_P10: st_nx = blm_pkg::ST_P11;
			blm_pkg::ST_P11: if (sts.mul_done) st_nx = blm_pkg::ST_P12;
			blm_pkg::ST_P12: st_nx = sts.reject ? blm_pkg::ST_G0 : blm_pkg::ST_DIV;
			blm_pkg::ST_DIV: if (sts.div_done) st_nx = blm_pkg::ST_D1;
			blm_pkg::ST_D1: st_nx = blm_pkg::ST_D2;
			blm_pkg::ST_D2: st_nx = blm_pkg::ST_F0;
			blm_pkg::ST_G0: st_nx = blm_pkg::ST_G1;
			blm_pkg::ST_G1: if (sts.mul_done) st_nx = blm_pkg::ST_F0;
			blm_pkg::ST_F0: st_nx = blm_pkg::ST_OSTEP;
			blm_pkg::ST_OSTART, blm_pkg::ST_OSTEP, blm_pkg::ST_OFIN:
				if (out_free) st_nx = blm_pkg::ST_WAIT;
			default: st_nx = blm_pkg::ST_WAIT;
		endcase
	end

	// state, phase, unit busy flag and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= blm_pkg::ST_WAIT;
			phase_q   <= blm_pkg::PH_IDLE;
			busy_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (cmd.mul_go || cmd.div_go) busy_q <= 1'b1;
			else if (sts.mul_done || sts.div_done) busy_q <= 1'b0;
			if (cmd.out_load) begin
				out_valid <= 1'b1;
				case (st_q)
					blm_pkg::ST_OSTART: phase_q <= blm_pkg::PH_FIRST;
					blm_pkg::ST_OSTEP:  phase_q <= blm_pkg::PH_STEP;
					default:            phase_q <= blm_pkg::PH_DONE;
				endcase
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// a unit finishes only while one was started
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(sts.mul_done || sts.div_done) |-> busy_q)
		else $error("unit done without a running operation");

	// no new request while a step is in progress
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mul_go || cmd.div_go || cmd.out_load) |-> !in_ready)
		else $error("input ready during a step");

	// a result is never overwritten before it is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("pending result lost");

	// a unit start is followed by waiting, not a second start
	a_single_go: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mul_go || cmd.div_go) |=> !(cmd.mul_go || cmd.div_go))
		else $error("unit started twice");
endmodule

// ----- sv/brent_line_minimizer_unit.sv -----
// Brent line minimiser working in a closed loop with an outside evaluator.
// in_ch carries requests: command start loads the bracket from the
// configuration registers, command value returns f at the last point asked.
// out_ch carries results: kind eval asks for f at point, kind done gives the
// best point and its value. Every start and every value taken in a running
// search gives exactly one result; values taken while idle or done are
// dropped. Configuration goes through cfg_we/cfg_index/cfg_data; the user
// must write it only while idle, which the block itself does not enforce.
// One request is handled at a time; in_ch.ready is high only between steps.
// A step after a value ends at the iteration limit or at the tolerance test,
// or takes a golden-section step, a parabolic step rejected to golden, or a
// parabolic step with the division. Steps use the shared multiplier (start,
// four partial products, hand-back; up to nine products) and the
// one-bit-a-cycle divider. A stalled receiver holds the result in the output
// register; the next step waits there until it is taken. Reset clears the
// search to idle and the configuration to bracket 0, rel_tol 1 and 100
// iterations.
module brent_line_minimizer_unit #(
	parameter int WORD_WIDTH = 64,
	parameter int ITER_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	blm_in_if.sink                        in_ch,
	blm_out_if.source                     out_ch,
	input  logic                          cfg_we,
	input  logic [blm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_WIDTH-1:0]         cfg_data
);
	blm_pkg::cmd_t    cmd;
	blm_pkg::status_t sts;
	logic             in_ready, out_valid;

	blm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_command(in_ch.command), .in_ready(in_ready),
		.out_ready(out_ch.ready), .out_valid(out_valid),
		.cmd(cmd), .sts(sts)
	);

	blm_datapath #(.W(WORD_WIDTH), .IW(ITER_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.func_value(in_ch.func_value),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.kind(out_ch.kind), .point(out_ch.point), .best_value(out_ch.best_value)
	);

	assign in_ch.ready  = in_ready;
	assign out_ch.valid = out_valid;
endmodule

// ----- bench/tb.sv -----
module tb;

	localparam longint MAXV = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint MINV = 64'sh8000_0000_0000_0000;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int ITEM_TARGET = 750;

	typedef struct packed {
		logic        command;
		logic [63:0] func_value;
	} request_t;

	typedef struct packed {
		logic        kind;
		logic [63:0] point;
		logic [63:0] best_value;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [blm_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [63:0] cfg_data;

	blm_in_if #(64) in_ch();
	blm_out_if #(64) out_ch();

	brent_line_minimizer_unit #(.WORD_WIDTH(64), .ITER_WIDTH(16)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// requests waiting for the driver, results still owed by the block
	request_t pending_requests[$];
	result_t expected_results[$];
	int queued_count = 0;
	int accepted_count = 0;
	int mismatch_count = 0;
	bit calm = 1'b0;

	// minimiser state and register copy
	longint cfg_low = 0, cfg_mid = 0, cfg_high = 0;
	bit [31:0] cfg_rtol = 32'd1;
	bit [15:0] cfg_maxit = 16'd100;
	longint lo_x = 0, hi_x = 0, bx = 0, sx = 0, tx = 0;
	longint bf = 0, sf = 0, tf = 0, step_cur = 0, step_old = 0, trial = 0;
	bit [15:0] iters = 0;
	logic [1:0] search_phase = blm_pkg::PH_IDLE;
	longint asked_point = 0;

	// saturating fixed point helpers
	function automatic longint sat_add(longint a, longint b);
		longint s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? MINV : MAXV;
		return s;
	endfunction

	function automatic longint sat_sub(longint a, longint b);
		longint s;
		s = a - b;
		if (a[63] != b[63] && s[63] != a[63]) s = a[63] ? MINV : MAXV;
		return s;
	endfunction

	function automatic bit [63:0] magn(longint a);
		return a < 0 ? 64'(-a) : 64'(a);
	endfunction

	function automatic longint signmag(bit neg, bit [63:0] m);
		if (neg) return (m >= 64'h8000_0000_0000_0000) ? MINV : -longint'(m);
		return (m > 64'h7FFF_FFFF_FFFF_FFFF) ? MAXV : longint'(m);
	endfunction

	function automatic longint abs_q(longint a);
		return signmag(1'b0, magn(a));
	endfunction

	function automatic longint half_q(longint a);
		return signmag(a < 0, magn(a) >> 1);
	endfunction

	function automatic longint mul_q(longint a, longint b);
		bit [127:0] pr;
		bit [63:0] m;
		pr = {64'b0, magn(a)} * {64'b0, magn(b)};
		m = (pr[127:96] != 0) ? '1 : pr[95:32];
		return signmag((a < 0) != (b < 0), m);
	endfunction

	function automatic longint div_q(longint p, longint q);
		bit [127:0] nq;
		bit [63:0] m;
		if (magn(q) == 0) return 0;
		nq = {32'b0, magn(p), 32'b0} / {64'b0, magn(q)};
		m = (nq[127:64] != 0) ? '1 : nq[63:0];
		return signmag((p < 0) != (q < 0), m);
	endfunction

	function automatic longint mid_q(longint a, longint b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		s = s >>> 1;
		return longint'(s[63:0]);
	endfunction

	// loop head: finish or pick the next trial point
	task automatic brent_next(output result_t r);
		longint x, a, b, tol1, tol2, xm, d, u, rr, qq, pp, prev;
		x = bx;
		a = lo_x;
		b = hi_x;
		if (iters >= cfg_maxit) begin
			search_phase = blm_pkg::PH_DONE;
			r = '{blm_pkg::KIND_DONE, bx, bf};
			return;
		end
		tol1 = sat_add(mul_q(abs_q(x), longint'({32'b0, cfg_rtol})), 1);
		tol2 = sat_add(tol1, tol1);
		xm = mid_q(a, b);
		if (abs_q(sat_sub(x, xm)) <= sat_sub(tol2, half_q(sat_sub(b, a)))) begin
			search_phase = blm_pkg::PH_DONE;
			r = '{blm_pkg::KIND_DONE, bx, bf};
			return;
		end
		if (abs_q(step_old) > tol1) begin
			rr = mul_q(sat_sub(x, sx), sat_sub(bf, tf));
			qq = mul_q(sat_sub(x, tx), sat_sub(bf, sf));
			pp = sat_sub(mul_q(sat_sub(x, tx), qq), mul_q(sat_sub(x, sx), rr));
			prev = step_old;
			qq = sat_add(sat_sub(qq, rr), sat_sub(qq, rr));
			if (qq > 0) pp = sat_sub(0, pp);
			qq = abs_q(qq);
			step_old = step_cur;
			if (abs_q(pp) >= abs_q(half_q(mul_q(qq, prev))) ||
					pp <= mul_q(qq, sat_sub(a, x)) || pp >= mul_q(qq, sat_sub(b, x))) begin
				step_old = (x >= xm) ? sat_sub(a, x) : sat_sub(b, x);
				d = mul_q(longint'({32'b0, blm_pkg::GOLD_Q}), step_old);
			end else begin
				d = div_q(pp, qq);
				u = sat_add(x, d);
				if (sat_sub(u, a) < tol2 || sat_sub(b, u) < tol2)
					d = (xm > x) ? tol1 : (xm < x) ? sat_sub(0, tol1) : 0;
			end
		end else begin
			step_old = (x >= xm) ? sat_sub(a, x) : sat_sub(b, x);
			d = mul_q(longint'({32'b0, blm_pkg::GOLD_Q}), step_old);
		end
		step_cur = d;
		if (abs_q(d) >= tol1)
			u = sat_add(x, d);
		else
			u = sat_add(x, d > 0 ? tol1 : d < 0 ? sat_sub(0, tol1) : 0);
		trial = u;
		if (iters != 16'hFFFF) iters++;
		search_phase = blm_pkg::PH_STEP;
		r = '{blm_pkg::KIND_EVAL, u, bf};
	endtask

	// fold a returned value into bracket and best points
	task automatic brent_take(longint fu);
		longint u, x;
		u = trial;
		x = bx;
		if (fu <= bf) begin
			if (u >= x) lo_x = x; else hi_x = x;
			tx = sx; sx = bx; bx = u;
			tf = sf; sf = bf; bf = fu;
		end else begin
			if (u < x) lo_x = u; else hi_x = u;
			if (fu <= sf || sx == x) begin
				tx = sx; sx = u;
				tf = sf; sf = fu;
			end else if (fu <= tf || tx == x || tx == sx) begin
				tx = u; tf = fu;
			end
		end
	endtask

	task automatic predict_request(request_t q);
		result_t r;
		if (q.command == blm_pkg::CMD_START) begin
			lo_x = cfg_low < cfg_high ? cfg_low : cfg_high;
			hi_x = cfg_low > cfg_high ? cfg_low : cfg_high;
			bx = cfg_mid; sx = cfg_mid; tx = cfg_mid; trial = cfg_mid;
			bf = 0; sf = 0; tf = 0;
			step_cur = 0; step_old = 0;
			iters = 0;
			search_phase = blm_pkg::PH_FIRST;
			r = '{blm_pkg::KIND_EVAL, cfg_mid, 64'd0};
		end else if (search_phase == blm_pkg::PH_FIRST) begin
			bf = longint'(q.func_value); sf = bf; tf = bf;
			brent_next(r);
		end else if (search_phase == blm_pkg::PH_STEP) begin
			brent_take(longint'(q.func_value));
			brent_next(r);
		end else begin
			return;
		end
		expected_results.push_back(r);
		asked_point = longint'(r.point);
	endtask

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 19);
		if (r < 12) return 0;
		if (r < 18) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// register copy follows the write port
	always @(posedge clk) begin
		if (cfg_we) begin
			case (cfg_index)
				blm_pkg::CFG_LOW: cfg_low = longint'(cfg_data);
				blm_pkg::CFG_MID: cfg_mid = longint'(cfg_data);
				blm_pkg::CFG_HIGH: cfg_high = longint'(cfg_data);
				blm_pkg::CFG_REL_TOL: cfg_rtol = cfg_data[31:0];
				blm_pkg::CFG_MAX_ITER: cfg_maxit = cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// request driver
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		request_t nxt;
		logic nxt_valid;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			send_gap = 0;
		end else begin
			nxt_valid = in_ch.valid;
			if (in_ch.valid && in_ch.ready) begin
				predict_request('{in_ch.command, in_ch.func_value});
				accepted_count++;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_requests.size() != 0) begin
					nxt = pending_requests.pop_front();
					in_ch.command <= nxt.command;
					in_ch.func_value <= nxt.func_value;
					nxt_valid = 1'b1;
					send_gap = pick_gap();
				end
			end
			in_ch.valid <= nxt_valid;
		end
	end

	// result receiver with random stalls and two long hold-offs
	int rx_cycle = 0;
	int rx_gap = 0;
	int hold_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			rx_cycle++;
			if (rx_cycle == 5000 || rx_cycle == 60000) hold_left = 400;
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_ch.ready <= 1'b0;
			end else begin
				rx_gap = pick_gap();
				out_ch.ready <= 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result kind %0d point %0h value %0h",
						out_ch.kind, out_ch.point, out_ch.best_value);
			end else begin
				want = expected_results.pop_front();
				if (out_ch.kind !== want.kind || out_ch.point !== want.point ||
						out_ch.best_value !== want.best_value) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result mismatch: expected kind %0d point %0h value %0h, got kind %0d point %0h value %0h",
							want.kind, want.point, want.best_value,
							out_ch.kind, out_ch.point, out_ch.best_value);
				end
			end
		end
	end

	// watchdog on cycles with no request and no result moved
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_request(logic cmd, longint f);
		pending_requests.push_back('{cmd, f});
		queued_count++;
		wait (accepted_count == queued_count);
	endtask

	task automatic wait_idle();
		wait (accepted_count == queued_count && expected_results.size() == 0);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [blm_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
	endtask

	task automatic load_settings(longint low, longint mid, longint high,
			bit [31:0] rt, bit [15:0] mi);
		wait_idle();
		write_reg(blm_pkg::CFG_LOW, low);
		write_reg(blm_pkg::CFG_MID, mid);
		write_reg(blm_pkg::CFG_HIGH, high);
		write_reg(blm_pkg::CFG_REL_TOL, {32'b0, rt});
		write_reg(blm_pkg::CFG_MAX_ITER, {48'b0, mi});
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic longint rand_word();
		return longint'({$urandom, $urandom});
	endfunction

	// one search against a synthetic objective, possibly cut short
	task automatic run_search(int max_evals);
		int shape, n;
		longint centre, scale, f, dx;
		shape = $urandom_range(0, 3);
		centre = sat_add(cfg_mid, longint'($signed($urandom)) <<< $urandom_range(0, 8));
		scale = longint'($urandom_range(1, 64)) <<< 26;
		send_request(blm_pkg::CMD_START, rand_word());
		n = 0;
		while (n < max_evals && (search_phase == blm_pkg::PH_FIRST ||
				search_phase == blm_pkg::PH_STEP)) begin
			dx = sat_sub(asked_point, centre);
			case (shape)
				0: f = mul_q(mul_q(dx, dx), scale);
				1: f = rand_word();
				2: f = sat_add(mul_q(dx, dx), longint'($signed($urandom_range(0, 4095))) - 2048);
				default: f = longint'($urandom_range(0, 3)) <<< 32;
			endcase
			send_request(blm_pkg::CMD_VALUE, f);
			n++;
		end
		// a stray value: dropped if the search has ended, else taken as the next value
		if ($urandom_range(0, 3) == 0) send_request(blm_pkg::CMD_VALUE, rand_word());
	endtask

	initial begin
		longint low, high, span, mid;
		int kind_sel;
		in_ch.valid = 1'b0;
		in_ch.command = blm_pkg::CMD_START;
		in_ch.func_value = '0;
		out_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = blm_pkg::CFG_LOW;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: value while idle, degenerate bracket at reset settings
		send_request(blm_pkg::CMD_VALUE, MAXV);
		send_request(blm_pkg::CMD_START, 0);
		send_request(blm_pkg::CMD_VALUE, MINV);
		send_request(blm_pkg::CMD_VALUE, 0);

		// directed: widest bracket, zero tolerance, extreme values
		load_settings(MINV, 0, MAXV, 32'd0, 16'd4);
		send_request(blm_pkg::CMD_START, -1);
		send_request(blm_pkg::CMD_VALUE, MAXV);
		send_request(blm_pkg::CMD_VALUE, MINV);
		send_request(blm_pkg::CMD_VALUE, -1);
		send_request(blm_pkg::CMD_VALUE, 0);
		send_request(blm_pkg::CMD_VALUE, MAXV);
		// restart while a search is running
		send_request(blm_pkg::CMD_START, 0);
		send_request(blm_pkg::CMD_VALUE, 1);
		send_request(blm_pkg::CMD_START, 0);

		// no iterations, widest tolerance, swapped bracket, point outside
		load_settings(longint'(5) <<< 32, longint'(9) <<< 32, -(longint'(3) <<< 32),
			32'hFFFF_FFFF, 16'd0);
		send_request(blm_pkg::CMD_START, 0);
		send_request(blm_pkg::CMD_VALUE, 64'sh0123_4567_89AB_CDEF);
		load_settings(-(longint'(1) <<< 32), 0, longint'(1) <<< 32, 32'd0, 16'hFFFF);
		calm = 1'b1;
		run_search(40);
		calm = 1'b0;

		// random settings and searches
		while (queued_count < ITEM_TARGET) begin
			kind_sel = $urandom_range(0, 5);
			span = {$urandom_range(0, 15), $urandom};
			low = -span;
			high = longint'({$urandom_range(0, 15), $urandom});
			mid = mid_q(low, high);
			case (kind_sel)
				0: load_settings(low, mid, high, $urandom_range(0, 1 << 24),
					16'($urandom_range(20, 120)));
				1: load_settings(MINV, rand_word(), MAXV, 32'd0, 16'hFFFF);
				2: load_settings(high, mid, low, $urandom, 16'($urandom_range(1, 50)));
				3: load_settings(low, sat_add(high, span), high, $urandom_range(0, 255),
					16'($urandom_range(0, 30)));
				4: load_settings(low, mid, high, 32'hFFFF_FFFF, 16'($urandom_range(0, 5)));
				default: load_settings(rand_word(), rand_word(), rand_word(), $urandom,
					16'($urandom_range(0, 65535)));
			endcase
			calm = ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(1, 4)) begin
				if (queued_count < ITEM_TARGET)
					run_search($urandom_range(0, 3) == 0 ? $urandom_range(1, 5)
						: $urandom_range(10, 60));
			end
		end

		wait (accepted_count == queued_count && expected_results.size() == 0);
		repeat (300) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/blm_pkg.sv
sv/blm_if.sv
sv/blm_mul.sv
sv/blm_div.sv
sv/blm_datapath.sv
sv/blm_ctrl.sv
sv/brent_line_minimizer_unit.sv
bench/tb.sv
